// File: sv/ccsoc_pkg.sv
// Shared types and constants for the coulomb counter / SOC tracker.
// Used by ccsoc_div100 and coulomb_counter_soc_tracker; no dependencies.
`timescale 1ns / 1ps

package ccsoc_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_CAPACITY   = 3'd0;
	localparam logic [2:0] REG_EFFICIENCY = 3'd1;
	localparam logic [2:0] REG_FULL_VOLT  = 3'd2;
	localparam logic [2:0] REG_FULL_CURR  = 3'd3;
	localparam logic [2:0] REG_FULL_HOLD  = 3'd4;
	localparam logic [2:0] REG_SAVE_PER   = 3'd5;

	// reset values of the registers
	localparam logic [9:0]  RST_CAPACITY   = 10'd100;
	localparam logic [6:0]  RST_EFFICIENCY = 7'd100;
	localparam logic [16:0] RST_SAVE_PER   = 17'd60;

	// input kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_SET    = 1'b1;

	// charge scale: uA*ms per Ah and per percent of one Ah
	localparam logic [51:0] UAMS_PER_AH  = 52'd3600000000000;
	localparam logic [51:0] UAMS_PER_PCT = 52'd36000000000;

	localparam logic [26:0] MS_PER_MIN = 27'd60000;
	localparam logic [26:0] MS_PER_S   = 27'd1000;

	// width of the delta that goes through the divide-by-100 unit
	localparam int DIV_W = 60;
	localparam logic [7:0] DIVISOR = 8'd100;
	// delta used once a product reaches 2^60
	localparam logic [DIV_W-1:0] DELTA_CAP = 60'd1 << 53;

	localparam logic [6:0] PCT_FULL = 7'd100;
	localparam logic [6:0] PCT_NEAR = 7'd99;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_PREP = 10'b00_0000_0010,
		ST_SETM = 10'b00_0000_0100,
		ST_MUL  = 10'b00_0000_1000,
		ST_SAT  = 10'b00_0001_0000,
		ST_DIV  = 10'b00_0010_0000,
		ST_UPD  = 10'b00_0100_0000,
		ST_SOC  = 10'b00_1000_0000,
		ST_SDIV = 10'b01_0000_0000,
		ST_FULL = 10'b10_0000_0000
	} state_t;

	// request to the divide-by-100 unit
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
	} div_req_t;

	// status back from the divide-by-100 unit
	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

// File: sv/ccsoc_div100.sv
// Bit-serial divide by 100: one quotient bit per cycle, MSB first.
// Depends on ccsoc_pkg for widths and request/response types.
`timescale 1ns / 1ps

module ccsoc_div100 (
	input  logic                clk,
	input  logic                arst_n,
	input  ccsoc_pkg::div_req_t req,
	output ccsoc_pkg::div_rsp_t rsp
);

	logic [ccsoc_pkg::DIV_W-1:0] sh_q;
	logic [6:0]                  rem_q;
	logic [5:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [7:0]                  trial;
	logic                        qbit;

	// bring down the next dividend bit and try to subtract the divisor
	assign trial = {rem_q, sh_q[ccsoc_pkg::DIV_W-1]};
	assign qbit  = (trial >= ccsoc_pkg::DIVISOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(ccsoc_pkg::DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift quotient bits in as dividend bits leave
	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q  <= req.dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[ccsoc_pkg::DIV_W-2:0], qbit};
			rem_q <= qbit ? 7'(trial - ccsoc_pkg::DIVISOR) : trial[6:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = sh_q;

endmodule

// File: sv/coulomb_counter_soc_tracker.sv
// Coulomb counter with SOC tracking, full-charge timer and autosave; uses ccsoc_pkg, ccsoc_div100.
// Path per item: a first sample goes straight to the SOC divide; a set command or a zero-current sample
// skips the multiply; a discharging or capped charging sample takes 32 multiply steps, and a charging
// sample then also goes through the divide-by-100 unit; the SOC divide takes up to 9 steps.
// One item at a time: the next is taken in the cycle after the result is registered, later while
// an earlier result still waits on out_ready. Reset clears the tracked state and restores the registers.
`timescale 1ns / 1ps

module coulomb_counter_soc_tracker (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [26:0] cfg_wdata,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [31:0] now_ms,
	input  logic signed [31:0] bus_current_ua,
	input  logic [16:0] bus_voltage_mv,
	input  logic [7:0]  set_percent,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [51:0] charge_uams,
	output logic [6:0]  soc_percent,
	output logic        full_timer_active,
	output logic        full_reached,
	output logic        save_request
);

	ccsoc_pkg::state_t state_q;

	// configuration registers
	logic [9:0]  cap_q;
	logic [6:0]  eff_q;
	logic [16:0] fvolt_q;
	logic [26:0] fcurr_q;
	logic [10:0] fhold_q;
	logic [16:0] sper_q;

	// tracked state
	logic [51:0] charge_q;
	logic [31:0] last_sample_q;
	logic        have_last_q;
	logic        timing_q;
	logic [31:0] full_start_q;
	logic [31:0] last_save_q;

	// captured item
	logic        kind_q;
	logic [31:0] now_q;
	logic [31:0] cur_q;
	logic [16:0] volt_q;
	logic [7:0]  pct_q;

	// working registers
	logic [51:0] max_q;
	logic [31:0] mag_q;
	logic        neg_q;
	logic [26:0] hold_lim_q;
	logic [26:0] save_lim_q;
	logic [16:0] cp_q;
	logic [69:0] mcand_q;
	logic [69:0] acc_q;
	logic [31:0] esh_q;
	logic [4:0]  mcnt_q;
	logic [ccsoc_pkg::DIV_W-1:0] delta_q;
	logic [58:0] num_q;
	logic [59:0] dsr_q;
	logic [7:0]  quo_q;
	logic [3:0]  scnt_q;
	logic [6:0]  soc_q;

	// output register
	logic        out_valid_q;
	logic [51:0] o_charge_q;
	logic [6:0]  o_soc_q;
	logic        o_timing_q;
	logic        o_reached_q;
	logic        o_save_q;

	ccsoc_pkg::div_req_t div_req;
	ccsoc_pkg::div_rsp_t div_rsp;

	ccsoc_div100 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// prep-stage values from the captured item
	logic        cur_neg;
	logic [31:0] cur_mag;
	logic [6:0]  eff_sat;
	logic [7:0]  pct_sat;
	logic [37:0] xprod;
	logic [31:0] elapsed;

	assign cur_neg = cur_q[31];
	assign cur_mag = cur_neg ? (~cur_q + 32'd1) : cur_q;
	assign eff_sat = (eff_q > ccsoc_pkg::PCT_FULL) ? ccsoc_pkg::PCT_FULL : eff_q;
	assign pct_sat = (pct_q > 8'(ccsoc_pkg::PCT_FULL)) ? 8'(ccsoc_pkg::PCT_FULL) : pct_q;
	assign xprod   = cur_neg ? (38'(cur_mag) * 38'(eff_sat)) : 38'(cur_mag);
	assign elapsed = now_q - last_sample_q;

	// charge update with clamp
	logic [60:0] upd_sum;
	logic [60:0] upd_val;
	always_comb begin
		upd_sum = 61'(charge_q) + 61'(delta_q);
		if (neg_q) begin
			upd_val = upd_sum;
		end else if (61'(delta_q) >= 61'(charge_q)) begin
			upd_val = '0;
		end else begin
			upd_val = 61'(charge_q) - 61'(delta_q);
		end
	end

	// soc divide step
	logic [59:0] sdiv_diff;
	logic        sdiv_ge;
	assign sdiv_ge   = ({1'b0, num_q} >= dsr_q);
	assign sdiv_diff = {1'b0, num_q} - dsr_q;

	// full-charge timer and autosave decision
	logic        out_free;
	logic        cond;
	logic        n_timing;
	logic        n_reached;
	logic        n_save;
	logic        n_to_max;
	logic        n_start;
	logic        n_saved;
	logic [31:0] since_full;
	logic [31:0] since_save;
	logic [6:0]  n_soc;

	assign out_free   = !out_valid_q || out_ready;
	assign since_full = now_q - full_start_q;
	assign since_save = now_q - last_save_q;
	assign cond = (volt_q >= fvolt_q) && !neg_q && (mag_q != '0) &&
		(mag_q < 32'(fcurr_q)) && (soc_q < ccsoc_pkg::PCT_NEAR);

	always_comb begin
		n_timing  = timing_q;
		n_reached = 1'b0;
		n_save    = 1'b0;
		n_to_max  = 1'b0;
		n_start   = 1'b0;
		n_saved   = 1'b0;
		if (kind_q == ccsoc_pkg::KIND_SET) begin
			n_save = 1'b1;
		end else begin
			if (cond) begin
				if (!timing_q) begin
					n_timing = 1'b1;
					n_start  = 1'b1;
				end else if (since_full >= 32'(hold_lim_q)) begin
					n_to_max  = 1'b1;
					n_timing  = 1'b0;
					n_reached = 1'b1;
					n_save    = 1'b1;
				end
			end else begin
				n_timing = 1'b0;
			end
			if (since_save >= 32'(save_lim_q)) begin
				n_saved = 1'b1;
				n_save  = 1'b1;
				if (n_timing) begin
					n_to_max = 1'b1;
				end
			end
		end
		if (n_to_max) begin
			n_soc = (max_q == '0) ? 7'd0 : ccsoc_pkg::PCT_FULL;
		end else begin
			n_soc = soc_q;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= ccsoc_pkg::RST_CAPACITY;
			eff_q   <= ccsoc_pkg::RST_EFFICIENCY;
			fvolt_q <= '0;
			fcurr_q <= '0;
			fhold_q <= '0;
			sper_q  <= ccsoc_pkg::RST_SAVE_PER;
		end else if (cfg_we) begin
			case (cfg_addr)
				ccsoc_pkg::REG_CAPACITY:   cap_q   <= cfg_wdata[9:0];
				ccsoc_pkg::REG_EFFICIENCY: eff_q   <= cfg_wdata[6:0];
				ccsoc_pkg::REG_FULL_VOLT:  fvolt_q <= cfg_wdata[16:0];
				ccsoc_pkg::REG_FULL_CURR:  fcurr_q <= cfg_wdata[26:0];
				ccsoc_pkg::REG_FULL_HOLD:  fhold_q <= cfg_wdata[10:0];
				ccsoc_pkg::REG_SAVE_PER:   sper_q  <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	// sequencer and tracked state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ccsoc_pkg::ST_IDLE;
			charge_q      <= '0;
			last_sample_q <= '0;
			have_last_q   <= 1'b0;
			timing_q      <= 1'b0;
			full_start_q  <= '0;
			last_save_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// drop a taken result; the final state loads the next one itself
			if (out_valid_q && out_ready && state_q != ccsoc_pkg::ST_FULL) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ccsoc_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= ccsoc_pkg::ST_PREP;
					end
				end
				ccsoc_pkg::ST_PREP: begin
					if (kind_q == ccsoc_pkg::KIND_SET) begin
						state_q <= ccsoc_pkg::ST_SETM;
					end else if (!have_last_q) begin
						state_q <= ccsoc_pkg::ST_SOC;
					end else if (!cur_neg && cur_mag == '0) begin
						state_q <= ccsoc_pkg::ST_UPD;
					end else begin
						state_q <= ccsoc_pkg::ST_MUL;
					end
				end
				ccsoc_pkg::ST_SETM: begin
					charge_q <= 52'(cp_q) * ccsoc_pkg::UAMS_PER_PCT;
					state_q  <= ccsoc_pkg::ST_SOC;
				end
				ccsoc_pkg::ST_MUL: begin
					if (mcnt_q == '1) begin
						state_q <= ccsoc_pkg::ST_SAT;
					end
				end
				ccsoc_pkg::ST_SAT: begin
					if (acc_q[69:60] == '0 && neg_q) begin
						state_q <= ccsoc_pkg::ST_DIV;
					end else begin
						state_q <= ccsoc_pkg::ST_UPD;
					end
				end
				ccsoc_pkg::ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ccsoc_pkg::ST_UPD;
					end
				end
				ccsoc_pkg::ST_UPD: begin
					charge_q <= (upd_val > 61'(max_q)) ? max_q : upd_val[51:0];
					state_q  <= ccsoc_pkg::ST_SOC;
				end
				ccsoc_pkg::ST_SOC: begin
					state_q <= ccsoc_pkg::ST_SDIV;
				end
				ccsoc_pkg::ST_SDIV: begin
					if (max_q == '0 || scnt_q == '0 || (scnt_q == 4'd8 && sdiv_ge)) begin
						state_q <= ccsoc_pkg::ST_FULL;
					end
				end
				ccsoc_pkg::ST_FULL: begin
					if (out_free) begin
						state_q     <= ccsoc_pkg::ST_IDLE;
						out_valid_q <= 1'b1;
						if (n_to_max) begin
							charge_q <= max_q;
						end
						if (kind_q == ccsoc_pkg::KIND_SAMPLE) begin
							timing_q      <= n_timing;
							last_sample_q <= now_q;
							have_last_q   <= 1'b1;
							if (n_start) begin
								full_start_q <= now_q;
							end
							if (n_saved) begin
								last_save_q <= now_q;
							end
						end
					end
				end
				default: state_q <= ccsoc_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ccsoc_pkg::ST_IDLE: begin
				kind_q <= kind;
				now_q  <= now_ms;
				cur_q  <= bus_current_ua;
				volt_q <= bus_voltage_mv;
				pct_q  <= set_percent;
			end
			ccsoc_pkg::ST_PREP: begin
				max_q      <= 52'(cap_q) * ccsoc_pkg::UAMS_PER_AH;
				mag_q      <= cur_mag;
				neg_q      <= cur_neg;
				hold_lim_q <= 27'(fhold_q) * ccsoc_pkg::MS_PER_MIN;
				save_lim_q <= 27'(sper_q) * ccsoc_pkg::MS_PER_S;
				cp_q       <= 17'(cap_q) * 17'(pct_sat);
				mcand_q    <= 70'(xprod);
				acc_q      <= '0;
				esh_q      <= elapsed;
				mcnt_q     <= '0;
				delta_q    <= '0;
			end
			ccsoc_pkg::ST_MUL: begin
				// add the shifted multiplicand for each set bit of elapsed time
				if (esh_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= {mcand_q[68:0], 1'b0};
				esh_q   <= {1'b0, esh_q[31:1]};
				mcnt_q  <= mcnt_q + 5'd1;
			end
			ccsoc_pkg::ST_SAT: begin
				if (acc_q[69:60] != '0) begin
					delta_q <= ccsoc_pkg::DELTA_CAP;
				end else begin
					delta_q <= acc_q[59:0];
				end
			end
			ccsoc_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					delta_q <= div_rsp.quotient;
				end
			end
			ccsoc_pkg::ST_SOC: begin
				num_q  <= 59'(charge_q) * 59'(ccsoc_pkg::PCT_FULL);
				dsr_q  <= {max_q, 8'b0};
				quo_q  <= '0;
				scnt_q <= 4'd8;
			end
			ccsoc_pkg::ST_SDIV: begin
				// restoring divide, one quotient bit per step
				if (max_q == '0) begin
					soc_q <= '0;
				end else if (scnt_q == 4'd8) begin
					soc_q <= ccsoc_pkg::PCT_FULL;
				end else begin
					if (sdiv_ge) begin
						num_q <= sdiv_diff[58:0];
					end
					if (scnt_q == '0) begin
						if ({quo_q[6:0], sdiv_ge} > 8'(ccsoc_pkg::PCT_FULL)) begin
							soc_q <= ccsoc_pkg::PCT_FULL;
						end else begin
							soc_q <= {quo_q[5:0], sdiv_ge};
						end
					end
					quo_q <= {quo_q[6:0], sdiv_ge};
				end
				dsr_q  <= {1'b0, dsr_q[59:1]};
				scnt_q <= scnt_q - 4'd1;
			end
			ccsoc_pkg::ST_FULL: begin
				if (out_free) begin
					o_charge_q  <= n_to_max ? max_q : charge_q;
					o_soc_q     <= n_soc;
					o_timing_q  <= (kind_q == ccsoc_pkg::KIND_SAMPLE) ? n_timing : timing_q;
					o_reached_q <= n_reached;
					o_save_q    <= n_save;
				end
			end
			default: ;
		endcase
	end

	// start the divider when a charging product stays below the cap
	assign div_req.start    = (state_q == ccsoc_pkg::ST_SAT) && neg_q && (acc_q[69:60] == '0);
	assign div_req.dividend = acc_q[59:0];

	assign in_ready          = (state_q == ccsoc_pkg::ST_IDLE);
	assign out_valid         = out_valid_q;
	assign charge_uams       = o_charge_q;
	assign soc_percent       = o_soc_q;
	assign full_timer_active = o_timing_q;
	assign full_reached      = o_reached_q;
	assign save_request      = o_save_q;

endmodule
